>>> src/dsdr_pkg.sv
// Package: shared constants and controller types for the descending sort block.
`timescale 1ns / 1ps
`default_nettype none
package dsdr_pkg;
	localparam int DepthDefault = 64;
	localparam int ScoreW = 16;
	localparam int RankW = 7;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SEL_CLR,
		ST_SEL_SCAN,
		ST_SEL_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic read_sel;
		logic emit_take;
		logic clear_set;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic last_pick;
	} sts_t;
endpackage
`default_nettype wire

>>> src/dsdr_datapath.sv
// Datapath: score memory, selection scan, rank counter and output register.
`timescale 1ns / 1ps
`default_nettype none
module dsdr_datapath #(
	parameter int DEPTH = dsdr_pkg::DepthDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire dsdr_pkg::cmd_t cmd,
	output dsdr_pkg::sts_t sts,
	input  wire logic signed [dsdr_pkg::ScoreW-1:0] score_in,
	output logic signed [dsdr_pkg::ScoreW-1:0] out_score,
	output logic [dsdr_pkg::RankW-1:0] out_rank,
	output logic out_last
);
	import dsdr_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// Selection sort: each pass scans the store for the largest unused entry.
	logic signed [ScoreW-1:0] mem [DEPTH];
	logic [DEPTH-1:0] used_q;
	logic [CW-1:0] count_q, picked_q, scan_q;
	logic [AW-1:0] best_q;
	logic signed [ScoreW-1:0] best_val_q, rd_q, prev_q;
	logic best_ok_q, scan_valid_q, have_prev_q;
	logic [RankW-1:0] rank_q;
	logic [AW-1:0] scan_addr_q;
	logic scan_done_q;

	always_ff @(posedge clk) begin
		if (cmd.load && count_q < CW'(DEPTH))
			mem[count_q[AW-1:0]] <= score_in;
		rd_q <= mem[cmd.read_sel ? best_q : scan_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q <= '0;
			picked_q <= '0;
			scan_q <= '0;
			best_q <= '0;
			best_ok_q <= 1'b0;
			scan_valid_q <= 1'b0;
			scan_done_q <= 1'b0;
			scan_addr_q <= '0;
			have_prev_q <= 1'b0;
			rank_q <= '0;
			best_val_q <= '0;
			prev_q <= '0;
			out_score <= '0;
			out_rank <= '0;
			out_last <= 1'b0;
		end else begin
			if (cmd.load && count_q < CW'(DEPTH))
				count_q <= count_q + CW'(1);
			if (cmd.scan_start) begin
				scan_q <= '0;
				best_ok_q <= 1'b0;
				scan_valid_q <= 1'b0;
				scan_done_q <= 1'b0;
			end else if (cmd.scan_step) begin
				// read data rd_q is registered alongside scan_addr_q, so both refer to the same entry
				scan_valid_q <= (scan_q < count_q);
				scan_addr_q <= scan_q[AW-1:0];
				if (scan_q < count_q)
					scan_q <= scan_q + CW'(1);
				if (scan_valid_q && !used_q[scan_addr_q] &&
						(!best_ok_q || rd_q > best_val_q)) begin
					best_ok_q <= 1'b1;
					best_q <= scan_addr_q;
					best_val_q <= rd_q;
				end
				if (!scan_valid_q && scan_q != '0)
					scan_done_q <= 1'b1;
			end
			if (cmd.emit_take) begin
				used_q[best_q] <= 1'b1;
				picked_q <= picked_q + CW'(1);
				if (!have_prev_q || best_val_q != prev_q)
					rank_q <= rank_q + RankW'(1);
				out_rank <= (!have_prev_q || best_val_q != prev_q) ?
					rank_q + RankW'(1) : rank_q;
				prev_q <= best_val_q;
				have_prev_q <= 1'b1;
				out_score <= best_val_q;
				out_last <= (picked_q + CW'(1) == count_q);
			end
			if (cmd.clear_set) begin
				count_q <= '0;
				used_q <= '0;
				picked_q <= '0;
				rank_q <= '0;
				have_prev_q <= 1'b0;
			end
		end
	end

	assign sts.scan_done = scan_done_q;
	assign sts.last_pick = (picked_q + CW'(1) == count_q);
endmodule
`default_nettype wire

>>> src/dsdr_ctrl.sv
// Controller: sequences loading, selection passes and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module dsdr_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic in_last,
	input  wire logic out_busy,
	input  wire logic out_fire,
	input  wire dsdr_pkg::sts_t sts,
	output dsdr_pkg::cmd_t cmd,
	output logic in_ready,
	output logic out_valid
);
	import dsdr_pkg::*;
	state_t state_q, state_d;
	logic last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_take)
				last_q <= sts.last_pick;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = !out_busy;
				if (in_fire) begin
					cmd.load = 1'b1;
					if (in_last)
						state_d = ST_SEL_CLR;
				end
			end
			ST_SEL_CLR: begin
				cmd.scan_start = 1'b1;
				state_d = ST_SEL_SCAN;
			end
			ST_SEL_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_busy || out_fire) begin
					cmd.emit_take = 1'b1;
					state_d = ST_SEL_READ;
				end
			end
			ST_SEL_READ: begin
				if (last_q) begin
					cmd.clear_set = 1'b1;
					state_d = ST_LOAD;
				end else
					state_d = ST_SEL_CLR;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	assign out_valid = out_busy;
endmodule
`default_nettype wire

>>> src/descending_sort_dense_rank.sv
// Top level: descending sort with dense ranking over a stream of scores.
// Usage:
//   s_axis carries one score per word (tdata) with tlast closing the set.
//   Scores load at one per cycle into a store of DEPTH entries; once full,
//   further scores (the last one included) are dropped. Loading stalls
//   while a result waits on m_axis. After the tlast word the block picks
//   the largest remaining score by a linear scan of the store, one entry
//   per cycle. m_axis gives each score in descending order with its dense
//   rank; equal scores share a rank, the first gets rank 1. tlast marks the
//   final word. s_axis_tready is low from the tlast word until the final
//   result has been taken. A stalled m_axis holds its word; the next scan
//   still runs and its result waits. Reset empties the set and the output
//   register; store contents are not cleared and are never used before
//   being written.
`timescale 1ns / 1ps
`default_nettype none
module descending_sort_dense_rank #(
	parameter int DEPTH = dsdr_pkg::DepthDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [15:0] s_axis_tdata, // [15:0] score
	input  wire logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [23:0] m_axis_tdata, // [15:0] sorted_score, [22:16] rank
	output logic m_axis_tlast
);
	import dsdr_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic valid_q, in_fire, out_fire;
	logic signed [ScoreW-1:0] o_score;
	logic [RankW-1:0] o_rank;
	logic o_last;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.emit_take)
			valid_q <= 1'b1;
		else if (out_fire)
			valid_q <= 1'b0;
	end

	dsdr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_axis_tlast),
		.out_busy(valid_q), .out_fire(out_fire), .sts(sts), .cmd(cmd),
		.in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
	);

	dsdr_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.score_in(s_axis_tdata), .out_score(o_score), .out_rank(o_rank),
		.out_last(o_last)
	);

	assign m_axis_tdata = {1'b0, o_rank, o_score};
	assign m_axis_tlast = o_last;
endmodule
`default_nettype wire
